// ----- hdl/rrsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsd_pkg: shared types and constants of the RLE RGB sprite decoder
// Transaction payloads, parser phase codes, register indexes and fixed limits.
// ----------------------------------------------------------------------------
package rrsd_pkg;

  // input transaction: one stream byte plus the row start flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_begin;
  } in_item_t;

  // result transaction: one opaque pixel write
  typedef struct packed {
    logic [15:0] pixel_row;
    logic [15:0] pixel_column;
    logic [31:0] pixel_argb;
    logic [28:0] opaque_total;
  } out_item_t;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SHAPE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_BITMAP = 2'd1;

  // parser phases
  localparam int unsigned PH_BITS = 3;
  localparam logic [PH_BITS-1:0] PH_IDLE  = 3'd0;
  localparam logic [PH_BITS-1:0] PH_COUNT = 3'd1;
  localparam logic [PH_BITS-1:0] PH_GAP   = 3'd2;
  localparam logic [PH_BITS-1:0] PH_LEN   = 3'd3;
  localparam logic [PH_BITS-1:0] PH_PIX   = 3'd4;
  localparam logic [PH_BITS-1:0] PH_DONE  = 3'd5;

  // byte positions within a field or a pixel
  localparam logic [1:0] BYTE_FIRST  = 2'd0;
  localparam logic [1:0] BYTE_SECOND = 2'd1;
  localparam logic [1:0] BYTE_THIRD  = 2'd2;
  localparam logic [1:0] BYTE_LAST   = 2'd3;

  localparam int unsigned BytesPerPixel = 3;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [28:0] OPAQUE_MAX    = 29'h1000_0000;

endpackage

// ----- hdl/rrsd_col_advance.sv -----
// ----------------------------------------------------------------------------
// rrsd_col_advance: column skip for one run gap
// Adds gap/3 to the column, saturating at the top of the column range.
// ----------------------------------------------------------------------------
module rrsd_col_advance #(
  parameter int COORD_BITS = 16
) (
  input  logic [31:0]         gap_bytes,
  input  logic [COORD_BITS:0] column_in,
  output logic [COORD_BITS:0] column_out
);

  localparam logic [COORD_BITS:0] COL_MAX = '1;
  // any gap at or above this skips past the column limit
  localparam logic [31:0] GAP_LIM = 32'(rrsd_pkg::BytesPerPixel) << (COORD_BITS + 1);
  // below GAP_LIM the gap fits DIV_N bits; reciprocal multiply with 2 extra bits
  localparam int DIV_N = COORD_BITS + 3;
  localparam int DIV_K = DIV_N + 2;
  localparam logic [DIV_K-1:0] DIV_M =
    DIV_K'(((64'd1 << DIV_K) + 64'd2) / 64'(rrsd_pkg::BytesPerPixel));

  logic                     huge;
  logic [DIV_N+DIV_K-1:0]   prod;
  logic [DIV_N-1:0]         adv;
  logic [COORD_BITS+1:0]    sum;

  assign huge = (gap_bytes >= GAP_LIM);
  assign prod = (DIV_N+DIV_K)'(gap_bytes[DIV_N-1:0]) * (DIV_N+DIV_K)'(DIV_M);
  assign adv  = prod[DIV_N+DIV_K-1:DIV_K];
  assign sum  = (COORD_BITS+2)'(column_in) + (COORD_BITS+2)'(adv[COORD_BITS:0]);

  always_comb begin
    if (huge || (sum > (COORD_BITS+2)'(COL_MAX))) begin
      column_out = COL_MAX;
    end else begin
      column_out = sum[COORD_BITS:0];
    end
  end

endmodule

// ----- hdl/rle_rgb_sprite_decoder.sv -----
// ----------------------------------------------------------------------------
// rle_rgb_sprite_decoder: run-length 24bpp sprite decoder
// Parses a sprite byte stream and emits opaque ARGB pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one stream byte per transaction (data_byte, row_begin). In run
//            mode row_begin flags the first byte of each row stream.
//   out_*  : one pixel write per transaction: row, column, ARGB, and the
//            running opaque count including this write.
//   cfg_*  : plain write port; index 0 = shape_width, 1 = full_bitmap_mode.
//            A write to index 0 or 1 restarts the parser (opaque count is kept).
//            Write only while the decoder is idle.
// Timing:
//   Input register -> single-pass parser logic -> result register. A byte
//   accepted into the input register is parsed when it advances, and its
//   pixel (if any) is captured in the result register and shown on out_*:
//   two register stages. One byte per cycle while out_* is not stalled; the
//   parser state update is a single combinational pass, with the gap/3
//   column skip done by one reciprocal multiply in the same pass. A stalled
//   result holds in the result register; the one-entry input register fills, then in_ready drops.
// Reset:
//   rst_n (sync, active low) clears the parser, the opaque count and both
//   valid flags; shape_width returns to 1 and run mode is selected.
// ----------------------------------------------------------------------------
module rle_rgb_sprite_decoder #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rrsd_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rrsd_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [rrsd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rrsd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam logic [COORD_BITS:0] COL_MAX = '1;

  // configuration
  logic [15:0] shape_width_r;
  logic        full_r;

  // input and result stages
  rrsd_pkg::in_item_t  in_r;
  logic                in_valid_r;
  rrsd_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                advance;

  // parser state
  logic [rrsd_pkg::PH_BITS-1:0] ph_r, ph_nxt;
  logic [1:0]                   bi_r, bi_nxt;
  logic [31:0]                  fs_r, fs_nxt;
  logic [31:0]                  rl_r, rl_nxt;
  logic [31:0]                  pl_r, pl_nxt;
  logic [COORD_BITS:0]          col_r, col_nxt;
  logic [COORD_BITS-1:0]        row_r, row_nxt;
  logic [15:0]                  ch_r, ch_nxt;
  logic [28:0]                  oc_r, oc_nxt;

  // per-byte working values
  logic [7:0]            b;
  logic [31:0]           field_raw;
  logic [31:0]           field_cur;
  logic                  field_done;
  logic [COORD_BITS:0]   col_gap;
  logic [COORD_BITS-1:0] w;
  logic [COORD_BITS-1:0] w_full;
  logic [COORD_BITS:0]   col_inc;
  logic                  emit;
  logic [23:0]           rgb;
  logic                  cfg_hit;

  assign b       = in_r.data_byte;
  assign w       = shape_width_r[COORD_BITS-1:0];
  assign w_full  = (w == '0) ? COORD_BITS'(1) : w;
  assign col_inc = col_r + (COORD_BITS+1)'(1);

  // gap field as it completes this byte (only used in the gap phase, no row start)
  assign field_raw = fs_r | (32'(b) << {bi_r, 3'b000});

  rrsd_col_advance #(
    .COORD_BITS (COORD_BITS)
  ) u_col_advance (
    .gap_bytes  (field_raw),
    .column_in  (col_r),
    .column_out (col_gap)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cfg_hit = cfg_we && ((cfg_index == rrsd_pkg::CFG_SHAPE_WIDTH) ||
                              (cfg_index == rrsd_pkg::CFG_FULL_BITMAP));

  // parser: one byte per pass
  always_comb begin
    ph_nxt     = ph_r;
    bi_nxt     = bi_r;
    fs_nxt     = fs_r;
    rl_nxt     = rl_r;
    pl_nxt     = pl_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    ch_nxt     = ch_r;
    oc_nxt     = oc_r;
    emit       = 1'b0;
    rgb        = 24'h0;
    field_cur  = 32'h0;
    field_done = 1'b0;

    if (full_r) begin
      // packed RGB, row-major; black is transparent
      case (bi_r)
        rrsd_pkg::BYTE_FIRST: begin
          ch_nxt = {b, 8'h00};
          bi_nxt = rrsd_pkg::BYTE_SECOND;
        end
        rrsd_pkg::BYTE_SECOND: begin
          ch_nxt = {ch_r[15:8], b};
          bi_nxt = rrsd_pkg::BYTE_THIRD;
        end
        default: begin
          bi_nxt = rrsd_pkg::BYTE_FIRST;
          rgb    = {ch_r, b};
          emit   = (rgb != 24'h0);
          if (col_inc >= (COORD_BITS+1)'(w_full)) begin
            col_nxt = '0;
            row_nxt = row_r + COORD_BITS'(1);
          end else begin
            col_nxt = col_inc;
          end
        end
      endcase
    end else begin
      if (in_r.row_begin) begin
        row_nxt = (ph_r == rrsd_pkg::PH_IDLE) ? '0 : row_r + COORD_BITS'(1);
        col_nxt = '0;
        ph_nxt  = rrsd_pkg::PH_COUNT;
        bi_nxt  = rrsd_pkg::BYTE_FIRST;
        fs_nxt  = '0;
      end

      // little-endian 32-bit field assembly
      field_cur = fs_nxt | (32'(b) << {bi_nxt, 3'b000});

      case (ph_nxt)
        rrsd_pkg::PH_COUNT, rrsd_pkg::PH_GAP, rrsd_pkg::PH_LEN: begin
          if (bi_nxt == rrsd_pkg::BYTE_LAST) begin
            field_done = 1'b1;
            bi_nxt     = rrsd_pkg::BYTE_FIRST;
            fs_nxt     = '0;
          end else begin
            bi_nxt = bi_nxt + 2'd1;
            fs_nxt = field_cur;
          end
          if (field_done) begin
            case (ph_nxt)
              rrsd_pkg::PH_COUNT: begin
                rl_nxt = field_cur;
                ph_nxt = (field_cur == 32'h0) ? rrsd_pkg::PH_DONE : rrsd_pkg::PH_GAP;
              end
              rrsd_pkg::PH_GAP: begin
                col_nxt = col_gap;
                ph_nxt  = rrsd_pkg::PH_LEN;
              end
              default: begin
                pl_nxt = field_cur;
                if (field_cur == 32'h0) begin
                  rl_nxt = rl_r - 32'd1;
                  ph_nxt = (rl_nxt == 32'h0) ? rrsd_pkg::PH_DONE : rrsd_pkg::PH_GAP;
                end else begin
                  ph_nxt = rrsd_pkg::PH_PIX;
                end
              end
            endcase
          end
        end
        rrsd_pkg::PH_PIX: begin
          case (bi_r)
            rrsd_pkg::BYTE_FIRST: begin
              ch_nxt = {b, 8'h00};
              bi_nxt = rrsd_pkg::BYTE_SECOND;
            end
            rrsd_pkg::BYTE_SECOND: begin
              ch_nxt = {ch_r[15:8], b};
              bi_nxt = rrsd_pkg::BYTE_THIRD;
            end
            default: begin
              bi_nxt = rrsd_pkg::BYTE_FIRST;
              rgb    = {ch_r, b};
              emit   = (col_r < (COORD_BITS+1)'(w));
              if (col_r < COL_MAX) begin
                col_nxt = col_inc;
              end
              pl_nxt = pl_r - 32'd1;
              if (pl_nxt == 32'h0) begin
                rl_nxt = rl_r - 32'd1;
                ph_nxt = (rl_nxt == 32'h0) ? rrsd_pkg::PH_DONE : rrsd_pkg::PH_GAP;
              end
            end
          endcase
        end
        default: begin
          // idle or done: stray bytes are ignored
        end
      endcase
    end

    if (emit && (oc_r < rrsd_pkg::OPAQUE_MAX)) begin
      oc_nxt = oc_r + 29'd1;
    end
  end

  // configuration and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_width_r <= 16'd1;
      full_r        <= 1'b0;
      ph_r          <= rrsd_pkg::PH_IDLE;
      bi_r          <= rrsd_pkg::BYTE_FIRST;
      fs_r          <= '0;
      rl_r          <= '0;
      pl_r          <= '0;
      col_r         <= '0;
      row_r         <= '0;
      ch_r          <= '0;
      oc_r          <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == rrsd_pkg::CFG_SHAPE_WIDTH) begin
        shape_width_r <= cfg_wdata;
      end else begin
        full_r <= cfg_wdata[0];
      end
      ph_r  <= rrsd_pkg::PH_IDLE;
      bi_r  <= rrsd_pkg::BYTE_FIRST;
      fs_r  <= '0;
      rl_r  <= '0;
      pl_r  <= '0;
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else if (advance) begin
      ph_r  <= ph_nxt;
      bi_r  <= bi_nxt;
      fs_r  <= fs_nxt;
      rl_r  <= rl_nxt;
      pl_r  <= pl_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
      oc_r  <= oc_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r.pixel_row    <= 16'(row_r);
      out_r.pixel_column <= 16'(col_r);
      out_r.pixel_argb   <= {rrsd_pkg::ALPHA_OPAQUE, rgb};
      out_r.opaque_total <= oc_nxt;
    end
  end

  // a pending result always carries the current opaque count
  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.opaque_total == oc_r))
    else $error("pending result opaque_total differs from the counter");

  // the opaque count only grows, across config writes too
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (oc_r >= $past(oc_r)))
    else $error("opaque count went down");

  // bitmap mode only walks three bytes per pixel
  a_full_byte_index: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (bi_r != rrsd_pkg::BYTE_LAST))
    else $error("byte index out of range in full-bitmap mode");

endmodule
